// ===== hw/rtl/dlmb_pkg.sv =====
// shared types and constants for the depth linearize / mask / bounding box block
// no dependencies
`default_nettype none

package dlmb_pkg;

  localparam int DEPTH_BITS = 24;
  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = $clog2(MAX_DIM) + 1;   // config size width
  localparam int POS_W      = $clog2(MAX_DIM);       // column / row width
  localparam int PLANE_W    = 32;
  localparam int DEN_W      = PLANE_W + DEPTH_BITS + 1;
  localparam int FN_W       = 2 * PLANE_W;
  localparam int NUM_W      = FN_W + 10;             // fn * 1000
  localparam int X_W        = NUM_W + DEPTH_BITS + 2;
  localparam int T_W        = DEN_W + 11;            // den << 11
  localparam int TS_W       = T_W + 15;
  localparam int CMP_W      = 64;
  localparam int DIV_STEPS  = 16;
  localparam int CNT_W      = 4;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);
  localparam logic [PLANE_W-1:0] RESET_NEAR = PLANE_W'(1024);
  localparam logic [PLANE_W-1:0] RESET_FAR  = PLANE_W'(1024000);

  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_NEAR   = 3'd0;
  localparam logic [IDX_W-1:0] REG_FAR    = 3'd1;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_SCALE  = 3'd4;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic cmp;
    logic prep;
    logic sat;
    logic div;
    logic emit;
  } dlmb_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dlmb_sts_t;

  // clamp a configured size to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dlmb_ctrl.sv =====
// sequencer for one pixel: multiplies, compare, setup, saturation check, 16 divide steps, emit
// depends on dlmb_pkg
`default_nettype none

module dlmb_ctrl import dlmb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  dlmb_sts_t      sts,
  output dlmb_cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL1 = 9'b000000010,
    S_MUL2 = 9'b000000100,
    S_MUL3 = 9'b000001000,
    S_CMP  = 9'b000010000,
    S_PREP = 9'b000100000,
    S_SAT  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin cmd.mul1 = 1'b1; state_next = S_MUL2; end
      S_MUL2: begin cmd.mul2 = 1'b1; state_next = S_MUL3; end
      S_MUL3: begin cmd.mul3 = 1'b1; state_next = S_CMP; end
      S_CMP:  begin cmd.cmp  = 1'b1; state_next = S_PREP; end
      S_PREP: begin cmd.prep = 1'b1; state_next = S_SAT; end
      S_SAT: begin
        cmd.sat    = 1'b1;
        cnt_next   = CNT_W'(DIV_STEPS - 1);
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div  = 1'b1;
        cnt_next = cnt - CNT_W'(1);
        if (cnt == '0) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dlmb_dp.sv =====
// datapath: config registers, depth arithmetic, divider, raster counters, box, output register
// depends on dlmb_pkg
`default_nettype none

module dlmb_dp import dlmb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [IDX_W-1:0]      cfg_index,
  input  wire logic [PLANE_W-1:0]    cfg_data,
  input  wire logic [DEPTH_BITS-1:0] depth_code,
  input  dlmb_cmd_t                  cmd,
  output dlmb_sts_t                  sts,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [15:0]                depth_value,
  output logic                       mask_bit,
  output logic                       frame_last,
  output logic [POS_W-1:0]           box_left,
  output logic [POS_W-1:0]           box_top,
  output logic [POS_W-1:0]           box_right,
  output logic [POS_W-1:0]           box_bottom,
  output logic                       box_empty
);

  localparam logic [DEPTH_BITS:0] FULL_CODE = {1'b1, {DEPTH_BITS{1'b0}}};

  // config
  logic [PLANE_W-1:0] near_plane, far_plane;
  logic [DIM_W-1:0]   image_width, image_height;
  logic               scale_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_plane   <= RESET_NEAR;
      far_plane    <= RESET_FAR;
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
      scale_mode   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NEAR:   near_plane   <= cfg_data;
        REG_FAR:    far_plane    <= cfg_data;
        REG_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        REG_SCALE:  scale_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // arithmetic
  logic [DEPTH_BITS-1:0] code;
  logic [DEN_W-1:0]      p1, p2, den;
  logic [FN_W-1:0]       fn;
  logic [NUM_W-1:0]      num;
  logic [X_W-1:0]        x;
  logic [T_W-1:0]        t;
  logic [TS_W-1:0]       ts;
  logic                  fg, sat;
  logic [15:0]           q;
  logic [CMP_W-1:0]      lhs, rhs, nsh, d64;
  logic [NUM_W-1:0]      fn_w;
  logic                  ge;

  always_comb begin
    nsh  = CMP_W'({near_plane, {DEPTH_BITS{1'b0}}});
    d64  = CMP_W'(den);
    lhs  = (nsh << 6) + (nsh << 5) + (nsh << 2);
    rhs  = (d64 << 6) + (d64 << 5) + (d64 << 1) + d64;
    fn_w = NUM_W'(fn);
    ge   = x >= X_W'(ts);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) code <= depth_code;
    if (cmd.mul1) p1 <= DEN_W'(far_plane) * DEN_W'(FULL_CODE - {1'b0, code});
    if (cmd.mul2) p2 <= DEN_W'(near_plane) * DEN_W'(code);
    if (cmd.mul3) begin
      den <= p1 + p2;
      fn  <= FN_W'(far_plane) * FN_W'(near_plane);
    end
    if (cmd.cmp) begin
      fg  <= (den != '0) && ((far_plane == '0) || (lhs <= rhs));
      num <= scale_mode ? fn_w : (fn_w << 10) - (fn_w << 4) - (fn_w << 3);
    end
    if (cmd.prep) begin
      // round half up: (2num + d) / 2d, d = den << 10
      x <= X_W'({num, {(DEPTH_BITS + 1){1'b0}}}) + (X_W'(den) << 10);
      t <= T_W'(den) << 11;
      q <= '0;
    end
    if (cmd.sat) begin
      sat <= x >= X_W'({t, 16'b0});
      ts  <= TS_W'(t) << 15;
    end
    if (cmd.div) begin
      if (ge) x <= x - X_W'(ts);
      q  <= {q[14:0], ge};
      ts <= ts >> 1;
    end
  end

  // raster position and box
  logic [POS_W-1:0] col, row, max_col, max_row;
  logic [DIM_W-1:0] min_col, min_row;
  logic             any_fg;
  logic [DIM_W-1:0] w, h;
  logic [POS_W-1:0] wm1, hm1;
  logic [DIM_W-1:0] min_col_n, min_row_n;
  logic [POS_W-1:0] max_col_n, max_row_n;
  logic             row_end, last;
  logic [DIM_W-1:0] l, tp, r, b;

  always_comb begin
    w   = eff_dim(image_width);
    h   = eff_dim(image_height);
    wm1 = POS_W'(w - DIM_W'(1));
    hm1 = POS_W'(h - DIM_W'(1));
    min_col_n = min_col;
    max_col_n = max_col;
    min_row_n = min_row;
    max_row_n = max_row;
    if (fg) begin
      if (!any_fg) begin
        min_col_n = DIM_W'(col);
        max_col_n = col;
        min_row_n = DIM_W'(row);
        max_row_n = row;
      end else begin
        if (DIM_W'(col) < min_col) min_col_n = DIM_W'(col);
        if (col > max_col) max_col_n = col;
        if (DIM_W'(row) < min_row) min_row_n = DIM_W'(row);
        if (row > max_row) max_row_n = row;
      end
    end
    row_end = col >= wm1;
    last    = row_end && (row >= hm1);
    l  = (min_col_n != '0) ? min_col_n - DIM_W'(1) : '0;
    tp = (min_row_n != '0) ? min_row_n - DIM_W'(1) : '0;
    r  = DIM_W'(max_col_n) + DIM_W'(1);
    b  = DIM_W'(max_row_n) + DIM_W'(1);
    if (l  > DIM_W'(wm1)) l  = DIM_W'(wm1);
    if (tp > DIM_W'(hm1)) tp = DIM_W'(hm1);
    if (r  > DIM_W'(wm1)) r  = DIM_W'(wm1);
    if (b  > DIM_W'(hm1)) b  = DIM_W'(hm1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      min_col <= RESET_WIDTH;
      max_col <= '0;
      min_row <= RESET_HEIGHT;
      max_row <= '0;
      any_fg  <= 1'b0;
    end else if (cmd.emit) begin
      if (last) begin
        col     <= '0;
        row     <= '0;
        min_col <= w;
        max_col <= '0;
        min_row <= h;
        max_row <= '0;
        any_fg  <= 1'b0;
      end else begin
        min_col <= min_col_n;
        max_col <= max_col_n;
        min_row <= min_row_n;
        max_row <= max_row_n;
        any_fg  <= any_fg | fg;
        if (row_end) begin
          col <= '0;
          row <= row + POS_W'(1);
        end else begin
          col <= col + POS_W'(1);
        end
      end
    end
  end

  // output register
  logic box_ok;
  assign box_ok = last && (any_fg || fg);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      depth_value <= fg ? (sat ? 16'hFFFF : q) : 16'h0000;
      mask_bit    <= fg;
      frame_last  <= last;
      box_left    <= box_ok ? POS_W'(l)  : '0;
      box_top     <= box_ok ? POS_W'(tp) : '0;
      box_right   <= box_ok ? POS_W'(r)  : '0;
      box_bottom  <= box_ok ? POS_W'(b)  : '0;
      box_empty   <= last && !box_ok;
    end
  end

  assign sts.out_busy = out_valid && !out_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/depth_linearize_mask_bbox.sv =====
// top level: depth linearization with foreground mask and padded bounding box
// depends on dlmb_pkg, dlmb_ctrl, dlmb_dp
`default_nettype none

// usage
// - input channel: depth_code beats on in_valid / in_ready, one pixel per beat,
//   row order, depth_code is a fraction of 2^24
// - output channel: one result beat per pixel on out_valid / out_ready with
//   linear depth, mask bit, and on the last pixel of the frame the box fields
// - config: write near_plane, far_plane, image_width, image_height, scale_mode
//   through cfg_write / cfg_index / cfg_data while no pixel is in flight
// - one pixel at a time: 32-bit multiplies, compare, setup and saturation
//   states, then a 16-step restoring divider, one quotient bit a cycle
// - an accepted pixel passes the multiply, compare, setup, saturation, divide
//   and emit states before out_valid rises, and the next pixel is taken only
//   once the sequencer is back in idle; the divider steps take most of that time
// - the output register frees the sequencer: the next pixel is accepted while
//   a finished result still waits; if the receiver stalls, the following
//   result holds in its last step until the register drains
// - reset (rst, synchronous) restores the register defaults (640 x 480,
//   near 1.0, far 1000.0, millimetre scale) and restarts the frame at row 0,
//   column 0 with an empty box; no result is pending after reset

module depth_linearize_mask_bbox import dlmb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [IDX_W-1:0]      cfg_index,
  input  wire logic [PLANE_W-1:0]    cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [DEPTH_BITS-1:0] depth_code,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [15:0]                depth_value,
  output logic                       mask_bit,
  output logic                       frame_last,
  output logic [POS_W-1:0]           box_left,
  output logic [POS_W-1:0]           box_top,
  output logic [POS_W-1:0]           box_right,
  output logic [POS_W-1:0]           box_bottom,
  output logic                       box_empty
);

  dlmb_cmd_t cmd;   // sequencer strobes into the datapath
  dlmb_sts_t sts;   // output register back-pressure

  dlmb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dlmb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .depth_code  (depth_code),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .depth_value (depth_value),
    .mask_bit    (mask_bit),
    .frame_last  (frame_last),
    .box_left    (box_left),
    .box_top     (box_top),
    .box_right   (box_right),
    .box_bottom  (box_bottom),
    .box_empty   (box_empty)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/dlmb_checker.sv =====
// port-level checks for depth_linearize_mask_bbox, attached by bind
// depends on dlmb_pkg
`default_nettype none

module dlmb_props import dlmb_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [15:0]           depth_value,
  input wire logic                  mask_bit,
  input wire logic                  frame_last,
  input wire logic [POS_W-1:0]      box_left,
  input wire logic [POS_W-1:0]      box_top,
  input wire logic [POS_W-1:0]      box_right,
  input wire logic [POS_W-1:0]      box_bottom,
  input wire logic                  box_empty
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped under stall");

  // one pixel in flight: no accept right after an accept
  a_one_pixel: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second pixel taken while busy");

  // background pixels carry zero depth
  a_bg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mask_bit |-> depth_value == 16'h0000) else $error("background depth");

  // box fields only on the last pixel
  a_box_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_last |-> !box_empty && box_left == '0 && box_top == '0
      && box_right == '0 && box_bottom == '0) else $error("box outside frame end");

  // an empty frame cannot end on a foreground pixel
  a_empty_bg: assert property (@(posedge clk) disable iff (rst)
    out_valid && box_empty |-> !mask_bit) else $error("empty box with foreground");

endmodule

bind depth_linearize_mask_bbox dlmb_props u_dlmb_props (.*);

`default_nettype wire

// ===== tb/dlmb_checker.sv =====
// result checker for depth_linearize_mask_bbox: watches config, input and output beats,
// predicts each pixel result and compares it field by field; depends on dlmb_pkg
module dlmb_checker import dlmb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [IDX_W-1:0]      cfg_index,
  input  wire logic [PLANE_W-1:0]    cfg_data,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic [DEPTH_BITS-1:0] depth_code,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic [15:0]           depth_value,
  input  wire logic                  mask_bit,
  input  wire logic                  frame_last,
  input  wire logic [POS_W-1:0]      box_left,
  input  wire logic [POS_W-1:0]      box_top,
  input  wire logic [POS_W-1:0]      box_right,
  input  wire logic [POS_W-1:0]      box_bottom,
  input  wire logic                  box_empty,
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0]      depth;
    logic             mask;
    logic             last;
    logic [POS_W-1:0] left, top, right, bottom;
    logic             empty;
  } pixel_t;

  pixel_t pixel_q[$];

  logic [31:0] near_q, far_q;
  logic [12:0] width_q, height_q;
  logic        unscaled;
  logic [11:0] col, row;
  logic [12:0] col_min, row_min;
  logic [11:0] col_max, row_max;
  logic        seen_fg;

  assign pending = pixel_q.size();

  function automatic logic [12:0] usable_size(input logic [12:0] v);
    if (v == 0) return 13'd1;
    if (v > 13'd4096) return 13'd4096;
    return v;
  endfunction

  task automatic restart_frame();
    col = 0;
    row = 0;
    col_min = usable_size(width_q);
    row_min = usable_size(height_q);
    col_max = 0;
    row_max = 0;
    seen_fg = 0;
  endtask

  task automatic linearize_pixel(input logic [DEPTH_BITS-1:0] code, output pixel_t p);
    logic [63:0]  den;
    logic [159:0] lhs, rhs, num, dd, x, t, q;
    logic [12:0]  w, h;
    logic [12:0]  l, tp, r, b;
    logic         fg, row_end;
    den = 64'(far_q) * (64'd1 << DEPTH_BITS) - 64'(far_q) * 64'(code) + 64'(near_q) * 64'(code);
    w = usable_size(width_q);
    h = usable_size(height_q);
    p = '{default: '0};
    if (den == 0) fg = 0;
    else if (far_q == 0) fg = 1;
    else begin
      lhs = (160'(near_q) << DEPTH_BITS) * 100;
      rhs = 160'(den) * 99;
      fg = lhs <= rhs;
    end
    if (fg) begin
      // round half up: (2 num + d) / (2 d), saturate to 16 bits
      num = (160'(far_q) * 160'(near_q) << DEPTH_BITS) * (unscaled ? 1 : 1000);
      dd = 160'(den) << 10;
      x = (num << 1) + dd;
      t = dd << 1;
      q = x / t;
      p.depth = (q > 160'd65535) ? 16'hFFFF : q[15:0];
      if (!seen_fg) begin
        col_min = 13'(col);
        col_max = col;
        row_min = 13'(row);
        row_max = row;
        seen_fg = 1;
      end else begin
        if (13'(col) < col_min) col_min = 13'(col);
        if (col > col_max) col_max = col;
        if (13'(row) < row_min) row_min = 13'(row);
        if (row > row_max) row_max = row;
      end
    end
    p.mask = fg;
    row_end = 13'(col) >= w - 1;
    p.last = row_end && 13'(row) >= h - 1;
    if (p.last) begin
      if (!seen_fg) p.empty = 1;
      else begin
        l = col_min > 0 ? col_min - 1 : 13'd0;
        tp = row_min > 0 ? row_min - 1 : 13'd0;
        r = 13'(col_max) + 1;
        b = 13'(row_max) + 1;
        if (l > w - 1) l = w - 1;
        if (tp > h - 1) tp = h - 1;
        if (r > w - 1) r = w - 1;
        if (b > h - 1) b = h - 1;
        p.left = l[11:0];
        p.top = tp[11:0];
        p.right = r[11:0];
        p.bottom = b[11:0];
      end
      restart_frame();
    end else if (row_end) begin
      col = 0;
      row = row + 1;
    end else begin
      col = col + 1;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    pixel_t p;
    if (rst) begin
      near_q = RESET_NEAR;
      far_q = RESET_FAR;
      width_q = 13'd640;
      height_q = 13'd480;
      unscaled = 0;
      restart_frame();
      pixel_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_NEAR:   near_q = cfg_data;
          REG_FAR:    far_q = cfg_data;
          REG_WIDTH:  width_q = cfg_data[12:0];
          REG_HEIGHT: height_q = cfg_data[12:0];
          REG_SCALE:  unscaled = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        linearize_pixel(depth_code, p);
        pixel_q.push_back(p);
      end
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) report_mismatch("unexpected beat", 1, 0);
        else begin
          p = pixel_q.pop_front();
          if (depth_value !== p.depth) report_mismatch("depth_value", depth_value, p.depth);
          if (mask_bit !== p.mask) report_mismatch("mask_bit", mask_bit, p.mask);
          if (frame_last !== p.last) report_mismatch("frame_last", frame_last, p.last);
          if (box_left !== p.left) report_mismatch("box_left", box_left, p.left);
          if (box_top !== p.top) report_mismatch("box_top", box_top, p.top);
          if (box_right !== p.right) report_mismatch("box_right", box_right, p.right);
          if (box_bottom !== p.bottom) report_mismatch("box_bottom", box_bottom, p.bottom);
          if (box_empty !== p.empty) report_mismatch("box_empty", box_empty, p.empty);
        end
      end
    end
  end
endmodule

// ===== tb/depth_linearize_mask_bbox_tb.sv =====
// testbench top for depth_linearize_mask_bbox: drives config, pixel beats and output stalls
// depends on dlmb_pkg, dlmb_checker and the block itself
module depth_linearize_mask_bbox_tb;
  import dlmb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;   // margin after the last result, longer than the pixel latency

  logic                  clk = 0;
  logic                  rst;
  logic                  cfg_write;
  logic [IDX_W-1:0]      cfg_index;
  logic [PLANE_W-1:0]    cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [DEPTH_BITS-1:0] depth_code;
  logic                  out_valid;
  logic                  out_ready;
  logic [15:0]           depth_value;
  logic                  mask_bit, frame_last, box_empty;
  logic [POS_W-1:0]      box_left, box_top, box_right, box_bottom;
  int                    errors, pending;

  // idle and stall rates in percent for the current phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  depth_linearize_mask_bbox dut (.*);

  dlmb_checker checker_i (.*);

  // receiver: per-cycle random stall
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("depth_linearize_mask_bbox_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 0;
  endtask

  // block idle: all results back, then latency margin before touching registers
  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_camera(input logic [31:0] near_v, input logic [31:0] far_v,
                            input logic [12:0] w, input logic [12:0] h, input logic scale);
    wait_idle();
    write_reg(REG_NEAR, near_v);
    write_reg(REG_FAR, far_v);
    write_reg(REG_WIDTH, 32'(w));
    write_reg(REG_HEIGHT, 32'(h));
    write_reg(REG_SCALE, 32'(scale));
  endtask

  // one pixel beat; valid holds until accepted
  task automatic send_pixel(input logic [DEPTH_BITS-1:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    depth_code <= code;
    do @(posedge clk); while (!in_ready);
  endtask

  // mix of codes: full range, close to the far plane, close to the near plane
  function automatic logic [DEPTH_BITS-1:0] pick_code();
    case ($urandom_range(3))
      0: return 24'hFFFFFF - 24'($urandom_range(65535));
      1: return 24'($urandom_range(255));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_plane();
    case ($urandom_range(4))
      0: return 32'($urandom_range(1, 4096));
      1: return 32'($urandom_range(1024, 1024 * 2000));
      2: return 32'hFFFFFFFF - 32'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] near_v, far_v;
    logic [12:0] w, h;
    rst = 1;
    cfg_write <= 0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 0;
    depth_code <= '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: default registers, code extremes
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000001);
    send_pixel(24'h800000);
    send_pixel(24'hFFFFFE);
    send_pixel(24'hFF0000);
    in_valid <= 0;

    // both planes zero, zero sizes act as 1: every pixel ends an empty frame
    set_camera(32'd0, 32'd0, 13'd0, 13'd0, 1'b0);
    send_pixel(24'h000000);
    send_pixel(24'h123456);
    in_valid <= 0;

    // far plane zero: zero code is background, others foreground at depth 0
    set_camera(32'd1024, 32'd0, 13'd2, 13'd1, 1'b1);
    send_pixel(24'h000000);
    send_pixel(24'h000007);
    send_pixel(24'hABCDEF);
    send_pixel(24'h000000);
    in_valid <= 0;

    // maximal planes, oversized width acts as 4096
    set_camera(32'hFFFFFFFF, 32'hFFFFFFFF, 13'h1FFF, 13'd3, 1'b1);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    in_valid <= 0;

    // near beyond far, millimetre scale: every pixel is background with depth 0
    set_camera(32'd2048000, 32'd1024, 13'd3, 13'd2, 1'b0);
    for (int i = 0; i < 6; i++) send_pixel(i[0] ? 24'hFFFFFF : 24'h000010);
    in_valid <= 0;

    // random phases, cycling through idle / stall patterns
    for (int ph = 0; ph < 16; ph++) begin
      near_v = pick_plane();
      far_v = pick_plane();
      if ($urandom_range(1)) begin
        near_v = 32'($urandom_range(1, 8192));
        far_v = near_v * 32'($urandom_range(2, 5000));
      end
      w = 13'($urandom_range(1, 9));
      h = 13'($urandom_range(1, 6));
      if (ph == 3) h = 0;
      if (ph == 7) w = 13'h1FFF;
      if (ph == 9) begin
        w = 13'd4096;
        h = 13'd1;
      end
      // shrink the width mid-row so the long row ends early
      if (ph == 10) w = 13'd2;
      set_camera(near_v, far_v, w, h, 1'($urandom_range(1)));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int i = 0; i < 100; i++) send_pixel(pick_code());
      in_valid <= 0;
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    if (errors == 0) $display("depth_linearize_mask_bbox_tb: clean");
    else $display("depth_linearize_mask_bbox_tb: errors");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/dlmb_pkg.sv
hw/rtl/dlmb_ctrl.sv
hw/rtl/dlmb_dp.sv
hw/rtl/depth_linearize_mask_bbox.sv
hw/rtl/dlmb_checker.sv
tb/dlmb_checker.sv
tb/depth_linearize_mask_bbox_tb.sv
